[hdl/esev_pkg.sv]
// Shared constants, codes and control types of the eccentricity series evaluator.
// No dependencies; every other file of the block but esev_ram imports this package.
package esev_pkg;

	localparam int MAX_POWER   = 16;
	localparam int STORE_DEPTH = 1024;

	localparam int ROW_LEN = MAX_POWER / 2 + 1;
	localparam int S_SPAN  = 2 * MAX_POWER + 1;

	localparam int ADDR_W     = $clog2(STORE_DEPTH);
	localparam int LIN_SPAN_W = $clog2(3 * S_SPAN * ROW_LEN);
	localparam int LIN_W      = (LIN_SPAN_W > ADDR_W ? LIN_SPAN_W : ADDR_W) + 1;
	localparam int K_W        = $clog2(ROW_LEN + 1);
	localparam int EXP_W      = $clog2(MAX_POWER + 1);

	localparam int M_W     = 3;
	localparam int S_W     = 6;
	localparam int POWER_W = 5;
	localparam int ORDER_W = 5;
	localparam int COEF_W  = 32;
	localparam int ECC_W   = 16;
	localparam int VALUE_W = 48;
	localparam int MUL_W   = 32;
	localparam int TERM_W  = MUL_W + EXP_W;
	localparam int ACC_W   = VALUE_W + 2;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_READY = 2'd1,
		STATUS_BAD_M     = 2'd2,
		STATUS_ORDER     = 2'd3
	} status_t;

	typedef enum logic {
		REG_TABLE_ORDER = 1'b0,
		REG_TABLE_READY = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_POW,
		OP_MUL,
		OP_DMUL,
		OP_ACC
	} mac_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SETUP,
		ST_READ,
		ST_POW,
		ST_DMUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		mac_op_t                op;
		logic                   coef_zero;
		logic [ECC_W-1:0]       ecc;
		logic [EXP_W-1:0]       exp;
	} mac_ctl_t;

endpackage

[hdl/esev_if.sv]
// Request and result channels of the eccentricity series evaluator.
// Depends on esev_pkg for field widths and the status code type.
interface esev_req_if;
	import esev_pkg::*;

	logic                      valid;
	logic                      ready;
	cmd_t                      cmd;
	logic signed [M_W-1:0]     m_index;
	logic signed [S_W-1:0]     s_index;
	logic [POWER_W-1:0]        power;
	logic signed [COEF_W-1:0]  coefficient;
	logic [ECC_W-1:0]          ecc;
	logic                      deriv;

	modport source (
		output valid, cmd, m_index, s_index, power, coefficient, ecc, deriv,
		input  ready
	);
	modport sink (
		input  valid, cmd, m_index, s_index, power, coefficient, ecc, deriv,
		output ready
	);
endinterface

interface esev_rsp_if;
	import esev_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	status_t                   status;

	modport source (
		output valid, value, status,
		input  ready
	);
	modport sink (
		input  valid, value, status,
		output ready
	);
endinterface

[hdl/esev_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module esev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

[hdl/esev_mac.sv]
// Shared multiplier, power register and term accumulator of the evaluator.
// Depends on esev_pkg; driven op by op from esev_ctrl.
module esev_mac (
	input  logic                              clk,
	input  esev_pkg::mac_ctl_t                ctl,
	input  logic [esev_pkg::COEF_W-1:0]       rdata,
	output logic signed [esev_pkg::VALUE_W-1:0] sum
);
	import esev_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic [MUL_W-1:0]         pw_q;
	logic                     pw_one_q;
	logic [TERM_W-1:0]        t_q;
	logic                     neg_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [COEF_W-1:0]        coef;
	logic [MUL_W-1:0]         mag;
	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic [2*MUL_W-1:0]       prod;
	logic [MUL_W-1:0]         pw_step;
	logic signed [ACC_W-1:0]  term_x;

	assign coef = ctl.coef_zero ? '0 : rdata;
	assign mag  = coef[COEF_W-1] ? (~coef + MUL_W'(1)) : coef;

	always_comb begin
		case (ctl.op)
			OP_POW: begin
				mul_a = pw_q;
				mul_b = MUL_W'(ctl.ecc);
			end
			OP_MUL: begin
				mul_a = mag;
				mul_b = pw_q;
			end
			OP_DMUL: begin
				mul_a = t_q[MUL_W-1:0];
				mul_b = MUL_W'(ctl.exp);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// 1.0 in Q0.32 is not representable in 32 bits; the first step gives e itself
	assign pw_step = pw_one_q ? {ctl.ecc, {(MUL_W-ECC_W){1'b0}}} : prod[MUL_W+ECC_W-1:ECC_W];
	assign term_x  = ACC_W'(t_q);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_CLEAR: begin
				pw_one_q <= 1'b1;
				acc_q    <= '0;
			end
			OP_POW: begin
				pw_q     <= pw_step;
				pw_one_q <= 1'b0;
			end
			OP_MUL: begin
				t_q   <= pw_one_q ? TERM_W'(mag) : TERM_W'(prod[2*MUL_W-1:MUL_W]);
				neg_q <= coef[COEF_W-1];
			end
			OP_DMUL: begin
				t_q <= prod[TERM_W-1:0];
			end
			OP_ACC: begin
				acc_q <= neg_q ? acc_q - term_x : acc_q + term_x;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (acc_q > SAT_HI) begin
			sum = SAT_HI[VALUE_W-1:0];
		end else if (acc_q < SAT_LO) begin
			sum = SAT_LO[VALUE_W-1:0];
		end else begin
			sum = acc_q[VALUE_W-1:0];
		end
	end
endmodule

[hdl/esev_ctrl.sv]
// Sequencer of the evaluator: request decode, coefficient addressing, term loop.
// Depends on esev_pkg and esev_if; steers esev_mac and the coefficient RAM.
module esev_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	esev_req_if.sink                      req,
	input  logic [esev_pkg::ORDER_W-1:0]  table_order,
	input  logic                          table_ready,
	input  logic                          out_free,
	output logic                          done,
	output esev_pkg::status_t             status,
	output esev_pkg::mac_ctl_t            mac_ctl,
	output logic                          ram_we,
	output logic                          ram_re,
	output logic [esev_pkg::ADDR_W-1:0]   ram_addr,
	output logic [esev_pkg::COEF_W-1:0]   ram_wdata
);
	import esev_pkg::*;

	state_t state_q, state_d;

	// captured request
	logic signed [M_W-1:0]    m_q;
	logic signed [S_W-1:0]    s_q;
	logic [POWER_W-1:0]       p_q;
	logic [COEF_W-1:0]        coef_q;
	logic [ECC_W-1:0]         ecc_q;
	logic                     deriv_q;

	// loop state
	logic [K_W-1:0]           k_q, k_d;
	logic [K_W-1:0]           kmax_q, kmax_d;
	logic [EXP_W-1:0]         n_q, n_d;
	logic [EXP_W-1:0]         pexp_q, pexp_d;
	logic [LIN_W-1:0]         base_q, base_d;
	logic                     oob_q, oob_d;
	status_t                  status_q, status_d;

	// decode of the captured request
	logic signed [7:0]        m_x, s_x, p_x, diff, absd, half, a_v, mn, num;
	logic [7:0]               sidx;
	logic [1:0]               tbl;
	logic                     m_ok, in_range, pole_s, par_ok, p_max_ok, ld_ok;
	logic [K_W-1:0]           k_calc;
	logic [LIN_W-1:0]         base_lin, ld_lin, rd_lin;
	logic [EXP_W-1:0]         tx;

	assign m_x = {{(8-M_W){m_q[M_W-1]}}, m_q};
	assign s_x = {{(8-S_W){s_q[S_W-1]}}, s_q};
	assign p_x = {{(8-POWER_W){1'b0}}, p_q};

	always_comb begin
		diff     = s_x - m_x;
		absd     = diff[7] ? -diff : diff;
		in_range = absd <= p_x;
		m_ok     = (m_x == -8'sd2) || (m_x == 8'sd0) || (m_x == 8'sd2);
		pole_s   = (m_x != 8'sd0) && (s_x == 8'sd0);
		par_ok   = (diff[0] ^ p_x[0]) == 1'b0;
		p_max_ok = int'(p_q) <= MAX_POWER;
		ld_ok    = m_ok && p_max_ok && in_range && par_ok && !pole_s;
		half     = m_x >>> 1;
		a_v      = s_x - half;
		mn       = (half < a_v) ? half : a_v;
		num      = p_x - s_x + (mn <<< 1);
		k_calc   = num[K_W:1];
		tbl      = 2'(half + 8'sd1);
		sidx     = 8'(diff + 8'(MAX_POWER));
		base_lin = LIN_W'((int'(tbl) * S_SPAN + int'(sidx)) * ROW_LEN);
		ld_lin   = base_lin + LIN_W'(k_calc);
		rd_lin   = base_q + LIN_W'(k_q);
		tx       = n_q - EXP_W'(deriv_q);
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		kmax_d    = kmax_q;
		n_d       = n_q;
		pexp_d    = pexp_q;
		base_d    = base_q;
		oob_d     = oob_q;
		status_d  = status_q;
		req.ready = 1'b0;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = ADDR_W'(rd_lin);
		mac_ctl.op        = OP_NONE;
		mac_ctl.coef_zero = oob_q;
		mac_ctl.ecc       = ecc_q;
		mac_ctl.exp       = n_q;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.cmd == CMD_EVAL) ? ST_SETUP : ST_WRITE;
				end
			end
			ST_WRITE: begin
				// drop malformed loads and anything past the end of the store
				ram_addr = ADDR_W'(ld_lin);
				ram_we   = ld_ok && (ld_lin < LIN_W'(STORE_DEPTH));
				state_d  = ST_IDLE;
			end
			ST_SETUP: begin
				mac_ctl.op = OP_CLEAR;
				pexp_d     = '0;
				k_d        = '0;
				n_d        = EXP_W'(absd);
				kmax_d     = k_calc;
				base_d     = base_lin;
				status_d   = STATUS_OK;
				state_d    = ST_DONE;
				if (!table_ready) begin
					status_d = STATUS_NOT_READY;
				end else if (!in_range) begin
					status_d = STATUS_OK;
				end else if (!m_ok) begin
					status_d = STATUS_BAD_M;
				end else if (pole_s) begin
					status_d = STATUS_OK;
				end else if (p_q > table_order || !p_max_ok) begin
					status_d = STATUS_ORDER;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re = 1'b1;
				oob_d  = rd_lin >= LIN_W'(STORE_DEPTH);
				if (deriv_q && n_q == '0) begin
					// derivative of the constant term vanishes: skip it
					if (k_q == kmax_q) begin
						state_d = ST_DONE;
					end else begin
						k_d     = k_q + K_W'(1);
						n_d     = n_q + EXP_W'(2);
					end
				end else begin
					state_d = ST_POW;
				end
			end
			ST_POW: begin
				if (pexp_q == tx) begin
					mac_ctl.op = OP_MUL;
					state_d    = deriv_q ? ST_DMUL : ST_ACC;
				end else begin
					mac_ctl.op = OP_POW;
					pexp_d     = pexp_q + EXP_W'(1);
				end
			end
			ST_DMUL: begin
				mac_ctl.op = OP_DMUL;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				mac_ctl.op = OP_ACC;
				if (k_q == kmax_q) begin
					state_d = ST_DONE;
				end else begin
					k_d     = k_q + K_W'(1);
					n_d     = n_q + EXP_W'(2);
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ram_wdata         = coef_q;
	assign status            = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			kmax_q   <= '0;
			n_q      <= '0;
			pexp_q   <= '0;
			oob_q    <= 1'b0;
			status_q <= STATUS_OK;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			kmax_q   <= kmax_d;
			n_q      <= n_d;
			pexp_q   <= pexp_d;
			oob_q    <= oob_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		if (state_q == ST_IDLE && req.valid) begin
			m_q     <= req.m_index;
			s_q     <= req.s_index;
			p_q     <= req.power;
			coef_q  <= req.coefficient;
			ecc_q   <= req.ecc;
			deriv_q <= req.deriv;
		end
	end
endmodule

[hdl/eccentricity_series_evaluator.sv]
// Top level of the eccentricity series evaluator: APB registers, output register,
// sequencer, shared multiply-accumulate and coefficient RAM.
// Depends on esev_pkg, esev_if, esev_ram, esev_mac and esev_ctrl.
//
// Takes one request at a time. A load request gives no result. In an evaluate request
// every power step, term product and derivative scaling goes through the one shared
// 32x32 multiplier. The result sits in an output register, so a new request is taken
// while it waits. The coefficient RAM is not cleared after reset: every entry must be
// loaded before it is evaluated, and table_ready set over the register port.
module eccentricity_series_evaluator (
	input  logic                             clk,
	input  logic                             arst_n,
	esev_req_if.sink                         req,
	esev_rsp_if.source                       rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [esev_pkg::PADDR_W-1:0]     paddr,
	input  logic [esev_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [esev_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import esev_pkg::*;

	logic [ORDER_W-1:0]         table_order_q;
	logic                       table_ready_q;
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_value_q;
	status_t                    out_status_q;

	logic                       cfg_wr;
	cfg_reg_t                   cfg_sel;
	logic                       out_free;
	logic                       done;
	status_t                    status;
	mac_ctl_t                   mac_ctl;
	logic                       ram_we;
	logic                       ram_re;
	logic [ADDR_W-1:0]          ram_addr;
	logic [COEF_W-1:0]          ram_wdata;
	logic [COEF_W-1:0]          ram_rdata;
	logic signed [VALUE_W-1:0]  sum;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_order_q <= '0;
			table_ready_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_TABLE_ORDER: table_order_q <= pwdata[ORDER_W-1:0];
				REG_TABLE_READY: table_ready_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_TABLE_ORDER: prdata = APB_DATA_W'(table_order_q);
			REG_TABLE_READY: prdata = APB_DATA_W'(table_ready_q);
			default:         prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_value_q  <= sum;
			out_status_q <= status;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

	esev_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.table_order (table_order_q),
		.table_ready (table_ready_q),
		.out_free    (out_free),
		.done        (done),
		.status      (status),
		.mac_ctl     (mac_ctl),
		.ram_we      (ram_we),
		.ram_re      (ram_re),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata)
	);

	esev_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.rdata (ram_rdata),
		.sum   (sum)
	);

	esev_ram #(
		.WIDTH (COEF_W),
		.DEPTH (STORE_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// a load request never brings a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.cmd == CMD_LOAD && !rsp.valid) |=> !rsp.valid)
		else $error("result appeared after a load request");

	// every rejected evaluation reports a zero value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STATUS_OK) |-> (rsp.value == '0))
		else $error("nonzero value with an error status");

	// an evaluate request occupies the sequencer
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.cmd == CMD_EVAL) |=> !req.ready)
		else $error("request taken while an evaluation starts");
endmodule
